/* sv/hle_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hle_pkg
// Shared types and constants of the href link extractor: scan phase codes,
// character codes, register reset value and the result item layout.
// ----------------------------------------------------------------------------
package hle_pkg;

  localparam int BYTE_W          = 8;
  localparam int LEN_W           = 16;
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int PHASE_W         = 3;

  localparam logic [LEN_W-1:0] MAX_LEN_RST = 16'd1024;

  localparam logic [PHASE_W-1:0] PH_START = 3'd0;
  localparam logic [PHASE_W-1:0] PH_H     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_HR    = 3'd2;
  localparam logic [PHASE_W-1:0] PH_HRE   = 3'd3;
  localparam logic [PHASE_W-1:0] PH_HREF  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_EQ    = 3'd5;
  localparam logic [PHASE_W-1:0] PH_QUOTE = 3'd6;
  localparam logic [PHASE_W-1:0] PH_VALUE = 3'd7;

  localparam logic [BYTE_W-1:0] CH_H      = 8'h68;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_W-1:0] CH_E      = 8'h65;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3d;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              link_end;
    logic              truncated;
  } res_t;

endpackage
`default_nettype wire

/* sv/hle_scan.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hle_scan
// Scan state and next-state logic: matches href, the equals sign and the
// opening quote, counts value bytes and forms the result item.
// ----------------------------------------------------------------------------
module hle_scan
  import hle_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              advance,
  input  wire [BYTE_W-1:0] byte_in,
  input  wire [LEN_W-1:0]  max_len,
  output logic             res_vld,
  output res_t             res
);

  localparam int CMP_W = (COUNT_WIDTH > LEN_W) ? COUNT_WIDTH : LEN_W;

  logic [PHASE_W-1:0]     phase_r, phase_nxt;
  logic                   qsingle_r, qsingle_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;

  logic              is_ws;
  logic [BYTE_W-1:0] lc;
  logic [BYTE_W-1:0] quote;
  logic              do_val;
  logic [COUNT_WIDTH-1:0] base;
  logic              at_limit;

  always_comb begin
    is_ws    = (byte_in inside {[8'd9:8'd13], CH_SPACE});
    lc       = (byte_in inside {[8'h41:8'h5a]}) ? (byte_in | 8'h20) : byte_in;
    quote    = qsingle_r ? CH_SQUOTE : CH_DQUOTE;
    phase_nxt   = phase_r;
    qsingle_nxt = qsingle_r;
    count_nxt   = count_r;
    do_val      = 1'b0;
    base        = count_r;
    res_vld     = 1'b0;
    res         = '0;
    case (phase_r)
      PH_START: if (lc == CH_H) phase_nxt = PH_H;
      PH_H:     phase_nxt = (lc == CH_R) ? PH_HR : PH_START;
      PH_HR:    phase_nxt = (lc == CH_E) ? PH_HRE : PH_START;
      PH_HRE:   phase_nxt = (lc == CH_F) ? PH_HREF : PH_START;
      PH_HREF: begin
        if (!is_ws) phase_nxt = (byte_in == CH_EQUAL) ? PH_EQ : PH_START;
      end
      PH_EQ: begin
        if (!is_ws) begin
          if (byte_in == CH_DQUOTE || byte_in == CH_SQUOTE) begin
            qsingle_nxt = (byte_in == CH_SQUOTE);
            phase_nxt   = PH_QUOTE;
          end else begin
            phase_nxt = PH_START;
          end
        end
      end
      PH_QUOTE: begin
        if (!is_ws) begin
          if (byte_in == quote) begin
            phase_nxt = PH_START;
          end else begin
            do_val = 1'b1;
            base   = '0;
          end
        end
      end
      PH_VALUE: do_val = 1'b1;
      default:  phase_nxt = PH_START;
    endcase

    at_limit = (CMP_W'(base) >= CMP_W'(max_len)) || (&base);

    if (do_val) begin
      res_vld = 1'b1;
      if (byte_in == quote) begin
        phase_nxt    = PH_START;
        res.link_end = 1'b1;
      end else if (at_limit) begin
        phase_nxt     = (lc == CH_H) ? PH_H : PH_START;
        count_nxt     = base;
        res.link_end  = 1'b1;
        res.truncated = 1'b1;
      end else begin
        phase_nxt = PH_VALUE;
        count_nxt = base + 1'b1;
        res.data  = is_ws ? CH_SPACE : byte_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_START;
      qsingle_r <= 1'b0;
      count_r   <= '0;
    end else if (advance) begin
      phase_r   <= phase_nxt;
      qsingle_r <= qsingle_nxt;
      count_r   <= count_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/hle_out_buf.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// hle_out_buf
// Result register with one skid entry; ready toward the scanner is registered.
// ----------------------------------------------------------------------------
module hle_out_buf
  import hle_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        push_valid,
  input  wire res_t  push_res,
  output logic       push_ready,
  output logic       out_valid,
  output res_t       out_res,
  input  wire        out_ready
);

  logic out_valid_r;
  logic skid_valid_r;
  res_t out_res_r;
  res_t skid_res_r;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_res    = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      out_valid_r  <= skid_valid_r || push_valid;
      skid_valid_r <= 1'b0;
    end else if (push_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_res_r <= skid_valid_r ? skid_res_r : push_res;
    end else if (push_valid && !skid_valid_r) begin
      skid_res_r <= push_res;
    end
  end

endmodule
`default_nettype wire

/* sv/href_link_extractor_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// href_link_extractor_unit
// Streams text bytes and emits the quoted values of href attributes.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while in_ready is high, and its result, if any,
// goes from an input register through the combinational scan logic into an
// output register backed by one skid entry. Sustained rate is one item per
// cycle; a stall on the result side holds the input only once the skid entry
// is full. Bytes that produce no result never wait on the result side.
// ----------------------------------------------------------------------------
module href_link_extractor_unit
  import hle_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire [BYTE_W-1:0] in_byte,
  output logic             out_valid,
  input  wire              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic             out_link_end,
  output logic             out_truncated,
  input  wire              cfg_wr_en,
  input  wire [LEN_W-1:0]  cfg_wr_data
);

  logic [LEN_W-1:0]  max_len_r;
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              res_vld;
  res_t              res;
  logic              push_ready;
  logic              advance;
  res_t              out_res;

  assign advance  = s1_valid_r && (!res_vld || push_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RST;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
    end
  end

  hle_scan #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (s1_byte_r),
    .max_len (max_len_r),
    .res_vld (res_vld),
    .res     (res)
  );

  hle_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (s1_valid_r && res_vld),
    .push_res   (res),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_res    (out_res),
    .out_ready  (out_ready)
  );

  assign out_byte      = out_res.data;
  assign out_link_end  = out_res.link_end;
  assign out_truncated = out_res.truncated;

endmodule
`default_nettype wire
